[rtl/tmme_pkg.sv]
// Package for the tile median / MAD estimator.
// Holds capacity, widths and radix-select digit and mask helpers; no dependencies.
package tmme_pkg;
   localparam int MaxPixels = 4096;
   localparam int AddrW     = $clog2(MaxPixels);
   localparam int CountW    = AddrW + 1;
   localparam int PixW      = 32;
   localparam int ValW      = 31;
   localparam int DigitW    = 4;
   localparam int Bins      = 1 << DigitW;
   localparam int Passes    = (ValW + DigitW - 1) / DigitW;
   localparam int PassW     = $clog2(Passes + 1);

   typedef logic [ValW-1:0]   val_type;
   typedef logic [CountW-1:0] count_type;
   typedef logic [AddrW-1:0]  addr_type;

   // Digit of value v for radix pass p (pass 0 = most significant digit).
   function automatic logic [DigitW-1:0] digit_of(val_type v, logic [PassW-1:0] p);
      logic [DigitW*Passes-1:0] ext;
      logic [PassW-1:0]         q;
      ext = {{(DigitW*Passes-ValW){1'b0}}, v};
      q   = PassW'(Passes - 1) - p;
      return ext[q*DigitW +: DigitW];
   endfunction

   // Mask that keeps the digits already fixed before pass p.
   function automatic val_type prefix_mask(logic [PassW-1:0] p);
      logic [DigitW*Passes-1:0] m;
      m = '1;
      m = m << (DigitW * (Passes - 32'(p)));
      return m[ValW-1:0];
   endfunction
endpackage

[rtl/tmme_store.sv]
// Kept-pixel memory: one write port, one registered read port.
// Depends on tmme_pkg.
module tmme_store (
   input  logic                clock,
   input  logic                wr_en,
   input  tmme_pkg::addr_type  wr_addr,
   input  tmme_pkg::val_type   wr_data,
   input  tmme_pkg::addr_type  rd_addr,
   output tmme_pkg::val_type   rd_data
);
   tmme_pkg::val_type mem [tmme_pkg::MaxPixels];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

[rtl/tile_median_mad_estimator.sv]
// Top level of the tile median / MAD estimator.
// Depends on tmme_pkg and tmme_store.
//
//  channel | ports                                          | direction
//  req     | start, busy, req_pixel, req_last               | in (busy out)
//  rsp     | rsp_valid + rsp_background/scale/counts/ovf    | out, no backpressure
//
// A non-last beat is taken without leaving idle. On the last beat the block
// runs a radix select, 4-bit digits, 8 passes for the median and 8 for the
// deviation; each pass is a sweep over the n kept pixels through the single
// store read port, a drain, a bin scan and a setup step. With n = 0 the
// passes are skipped. busy drops in the strobe cycle; the receiver cannot
// stall. Reset clears counts and control, not the store.
module tile_median_mad_estimator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic signed [31:0]          req_pixel,
   input  logic                        req_last,
   output logic                        rsp_valid,
   output logic [30:0]                 rsp_background,
   output logic [30:0]                 rsp_scale,
   output logic [12:0]                 rsp_kept_count,
   output logic [12:0]                 rsp_pixel_count,
   output logic                        rsp_overflow
);
   typedef enum logic [2:0] {S_IDLE, S_SWEEP, S_DRAIN, S_PICK, S_NEXT, S_DONE} state_type;

   state_type                 state_ff;
   tmme_pkg::count_type       kept_ff, seen_ff;
   logic                      ovf_ff;
   logic                      phase_ff;      // 0: median, 1: deviation
   logic [tmme_pkg::PassW-1:0] pass_ff;
   tmme_pkg::count_type       rd_ff;          // read index during sweep
   logic                      rvalid_ff;      // rd_data holds valid read data
   tmme_pkg::val_type         prefix_ff;      // digits selected so far
   tmme_pkg::count_type       rank_ff;        // remaining rank inside prefix
   tmme_pkg::val_type         bg_ff;
   tmme_pkg::count_type       hist_ff [tmme_pkg::Bins];
   logic [tmme_pkg::DigitW-1:0] pick_ff;      // bin scan index
   tmme_pkg::count_type       acc_ff;

   tmme_pkg::val_type rd_data, cur_val;
   logic              wr_en;
   logic              pos;
   logic              full;

   assign full  = (seen_ff == tmme_pkg::count_type'(tmme_pkg::MaxPixels));
   assign pos   = !req_pixel[31] && (req_pixel != 32'sd0);
   assign wr_en = (state_ff == S_IDLE) && start && !full && pos;

   tmme_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (kept_ff[tmme_pkg::AddrW-1:0]),
      .wr_data (req_pixel[30:0]),
      .rd_addr (rd_ff[tmme_pkg::AddrW-1:0]),
      .rd_data (rd_data)
   );

   // value under selection: raw pixel or its deviation from background
   always_comb begin
      if (!phase_ff) cur_val = rd_data;
      else if (rd_data >= bg_ff) cur_val = rd_data - bg_ff;
      else cur_val = bg_ff - rd_data;
   end

   logic match;
   logic [tmme_pkg::DigitW-1:0] dig;
   assign match = ((cur_val ^ prefix_ff) & tmme_pkg::prefix_mask(pass_ff)) == '0;
   assign dig   = tmme_pkg::digit_of(cur_val, pass_ff);

   tmme_pkg::count_type bin_cnt;
   tmme_pkg::count_type acc_next;
   assign bin_cnt  = hist_ff[pick_ff[tmme_pkg::DigitW-1:0]];
   assign acc_next = acc_ff + bin_cnt;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         kept_ff   <= '0;
         seen_ff   <= '0;
         ovf_ff    <= 1'b0;
         rvalid_ff <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= (state_ff == S_DONE);
         unique case (state_ff)
            S_IDLE: if (start) begin
               if (full) ovf_ff <= 1'b1;
               else seen_ff <= seen_ff + 1'b1;
               if (wr_en) kept_ff <= kept_ff + 1'b1;
               if (req_last) begin
                  phase_ff  <= 1'b0;
                  pass_ff   <= '0;
                  prefix_ff <= '0;
                  bg_ff     <= '0;
                  rank_ff   <= (kept_ff + tmme_pkg::count_type'(wr_en)) >> 1;
                  rd_ff     <= '0;
                  for (int b = 0; b < tmme_pkg::Bins; b++) hist_ff[b] <= '0;
                  state_ff  <= ((kept_ff + tmme_pkg::count_type'(wr_en)) == '0)
                               ? S_DONE : S_SWEEP;
               end
            end
            S_SWEEP: begin
               rvalid_ff <= 1'b1;
               if (rvalid_ff && match) hist_ff[dig] <= hist_ff[dig] + 1'b1;
               if (rd_ff + 1'b1 == kept_ff) state_ff <= S_DRAIN;
               else rd_ff <= rd_ff + 1'b1;
            end
            S_DRAIN: begin
               // last read lands now
               if (rvalid_ff && match) hist_ff[dig] <= hist_ff[dig] + 1'b1;
               rvalid_ff <= 1'b0;
               pick_ff   <= '0;
               acc_ff    <= '0;
               state_ff  <= S_PICK;
            end
            S_PICK: begin
               if (acc_next > rank_ff) begin
                  rank_ff  <= rank_ff - acc_ff;
                  prefix_ff <= prefix_ff | (tmme_pkg::val_type'(pick_ff[tmme_pkg::DigitW-1:0])
                     << (tmme_pkg::DigitW * (tmme_pkg::Passes - 1 - 32'(pass_ff))));
                  state_ff <= S_NEXT;
               end else begin
                  acc_ff  <= acc_next;
                  pick_ff <= pick_ff + 1'b1;
               end
            end
            S_NEXT: begin
               for (int b = 0; b < tmme_pkg::Bins; b++) hist_ff[b] <= '0;
               rd_ff <= '0;
               if (pass_ff == tmme_pkg::PassW'(tmme_pkg::Passes - 1)) begin
                  pass_ff <= '0;
                  if (!phase_ff) begin
                     phase_ff  <= 1'b1;
                     bg_ff     <= prefix_ff;
                     prefix_ff <= '0;
                     rank_ff   <= kept_ff >> 1;
                     state_ff  <= S_SWEEP;
                  end else state_ff <= S_DONE;
               end else begin
                  pass_ff  <= pass_ff + 1'b1;
                  state_ff <= S_SWEEP;
               end
            end
            S_DONE: begin
               rsp_background  <= (kept_ff == '0) ? '0 : bg_ff;
               rsp_scale       <= (kept_ff == '0) ? '0 : prefix_ff;
               rsp_kept_count  <= kept_ff;
               rsp_pixel_count <= seen_ff;
               rsp_overflow    <= ovf_ff;
               kept_ff  <= '0;
               seen_ff  <= '0;
               ovf_ff   <= 1'b0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy = (state_ff != S_IDLE);
endmodule

[verif/tb_tile_median_mad_estimator.sv]
// Testbench for tile_median_mad_estimator: drives tiles of Q16.16 pixels,
// predicts median / MAD per tile in SV and checks every result beat.
// Depends on tmme_pkg and the RTL of tile_median_mad_estimator.
module tb_tile_median_mad_estimator;
   typedef struct packed {
      logic [31:0] pixel;
      logic        last;
   } pixel_beat_type;

   typedef struct packed {
      logic [30:0] background;
      logic [30:0] scale;
      logic [12:0] kept_count;
      logic [12:0] pixel_count;
      logic        overflow;
   } tile_stats_type;

   localparam int WatchdogLimit = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [31:0] req_pixel = '0;
   logic req_last = 1'b0;
   logic rsp_valid;
   logic [30:0] rsp_background, rsp_scale;
   logic [12:0] rsp_kept_count, rsp_pixel_count;
   logic rsp_overflow;

   tile_median_mad_estimator dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_pixel(req_pixel), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_background(rsp_background),
      .rsp_scale(rsp_scale), .rsp_kept_count(rsp_kept_count),
      .rsp_pixel_count(rsp_pixel_count), .rsp_overflow(rsp_overflow)
   );

   always #5 clock = ~clock;

   pixel_beat_type pending_pixels[$];
   tile_stats_type expected_stats[$];

   // predictor state for the open tile
   logic [31:0] tile_values[$];
   int seen_count = 0;
   bit ovf_seen = 0;

   int errors = 0;
   int beats_sent = 0;
   int tiles_checked = 0;
   int idle_cycles = 0;
   int gap_left = 0;

   function automatic logic [31:0] rank_value(logic [31:0] vals[$], int rank);
      logic [31:0] sorted[$];
      sorted = vals;
      sorted.sort();
      return sorted[rank];
   endfunction

   // Fold one accepted beat into the tile state; emit stats on last.
   task automatic account_pixel(pixel_beat_type b);
      tile_stats_type s;
      logic [31:0] devs[$];
      logic [31:0] bg;
      int n;
      if (seen_count >= tmme_pkg::MaxPixels) ovf_seen = 1;
      else begin
         seen_count++;
         if (b.pixel != 0 && !b.pixel[31]) tile_values.insert(tile_values.size(), b.pixel);
      end
      if (!b.last) return;
      n = tile_values.size();
      s = '0;
      if (n > 0) begin
         bg = rank_value(tile_values, n / 2);
         s.background = bg[30:0];
         foreach (tile_values[i])
            devs.insert(devs.size(), tile_values[i] >= bg ?
                        tile_values[i] - bg : bg - tile_values[i]);
         s.scale = 31'(rank_value(devs, n / 2));
      end
      s.kept_count = 13'(n);
      s.pixel_count = 13'(seen_count);
      s.overflow = ovf_seen;
      expected_stats.insert(expected_stats.size(), s);
      tile_values.delete();
      seen_count = 0;
      ovf_seen = 0;
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("MISMATCH tile %0d %s: got %0h want %0h", tiles_checked, what, got, want);
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return int'($urandom_range(1, 3));
      return int'($urandom_range(4, 30));
   endfunction

   function automatic logic [31:0] random_pixel(int style);
      case (style)
         0: return $urandom;
         1: return $urandom_range(1, 2000);
         2: return 32'h7FFF_FFFF - $urandom_range(0, 50);
         3: return 32'h8000_0000 | $urandom;
         default: return {1'b0, 31'($urandom)};
      endcase
   endfunction

   task automatic add_beat(logic [31:0] px, logic lst);
      pixel_beat_type b;
      b.pixel = px;
      b.last  = lst;
      pending_pixels.insert(pending_pixels.size(), b);
   endtask

   task automatic queue_tile(int len, int style);
      logic [31:0] px;
      for (int i = 0; i < len; i++) begin
         px = random_pixel(style == 5 ? int'($urandom_range(0, 4)) : style);
         if ($urandom_range(0, 9) == 0) px = 0;
         add_beat(px, i == len - 1);
      end
   endtask

   // driver: one beat per accepted start, random gaps between beats
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && busy) begin
         // hold the current beat
      end else begin
         if (start) begin
            account_pixel('{pixel: req_pixel, last: req_last});
            beats_sent++;
            gap_left = pick_gap();
         end
         if (gap_left == 0 && pending_pixels.size() > 0) begin
            pixel_beat_type b;
            b = pending_pixels.pop_front();
            req_pixel <= b.pixel;
            req_last <= b.last;
            start <= 1'b1;
         end else begin
            if (gap_left > 0) gap_left--;
            start <= 1'b0;
            req_pixel <= $urandom;
            req_last <= 1'($urandom_range(0, 1));
         end
      end
   end

   // monitor: compare each result strobe with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_stats.size() == 0) begin
            report_mismatch("unexpected result, background", 32'(rsp_background), 32'h0);
         end else begin
            tile_stats_type e;
            e = expected_stats.pop_front();
            if (rsp_background !== e.background)
               report_mismatch("background", 32'(rsp_background), 32'(e.background));
            if (rsp_scale !== e.scale)
               report_mismatch("scale", 32'(rsp_scale), 32'(e.scale));
            if (rsp_kept_count !== e.kept_count)
               report_mismatch("kept_count", 32'(rsp_kept_count), 32'(e.kept_count));
            if (rsp_pixel_count !== e.pixel_count)
               report_mismatch("pixel_count", 32'(rsp_pixel_count), 32'(e.pixel_count));
            if (rsp_overflow !== e.overflow)
               report_mismatch("overflow", 32'(rsp_overflow), 32'(e.overflow));
         end
         tiles_checked++;
      end
   end

   // watchdog: cycles with no beat accepted on either side
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("watchdog expired after %0d idle cycles", idle_cycles);
         $display("tile_median_mad_estimator test failed");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: empty tile, single pixels at the extremes, mixed signs
      add_beat(32'h0, 1'b1);
      add_beat(32'h8000_0000, 1'b1);
      add_beat(32'h7FFF_FFFF, 1'b1);
      add_beat(32'h1, 1'b1);
      add_beat(32'hFFFF_FFFF, 1'b0);
      add_beat(32'h1, 1'b0);
      add_beat(32'h7FFF_FFFF, 1'b1);
      add_beat(32'h5, 1'b0);
      add_beat(32'h5, 1'b0);
      add_beat(32'h9, 1'b0);
      add_beat(32'h2, 1'b1);

      // random tiles, mostly short
      while (pending_pixels.size() < 640) queue_tile($urandom_range(1, 12), $urandom_range(0, 5));
      queue_tile(5, 5);

      wait (pending_pixels.size() == 0 && !start);
      wait (expected_stats.size() == 0);
      repeat (200) @(posedge clock);
      $display("%0d pixel beats in %0d tiles checked: empty, extreme, mixed-sign tiles",
               beats_sent, tiles_checked);
      if (errors == 0 && expected_stats.size() == 0 && tile_values.size() == 0)
         $display("tile_median_mad_estimator test passed");
      else
         $display("tile_median_mad_estimator test failed");
      $finish;
   end
endmodule

[tile_median_mad_estimator.f]
rtl/tmme_pkg.sv
rtl/tmme_store.sv
rtl/tile_median_mad_estimator.sv
verif/tb_tile_median_mad_estimator.sv
